[hdl/jtsp_pkg.sv]
// Shared types, constants and tables of the joint-to-servo position and speed mapper.
// No dependencies; every other file takes names from here by scope.
package jtsp_pkg;

    localparam int ANGLE_W   = 13;
    localparam int TIME_W    = 16;
    localparam int TGT_W     = 16;
    localparam int SPD_W     = 16;
    localparam int SERVOS    = 5;
    localparam int JOINTS    = 4;
    localparam int IDX_W     = $clog2(SERVOS);
    localparam int COEF_W    = 6;
    // |acc| <= 76 * 4096 per row
    localparam int ACC_W     = 21;
    // |acc| << 8 and diff * 1000 both fit in 27 bits
    localparam int DIV_W     = 27;
    localparam int DEN_W     = 16;

    localparam int ANGLE_FRACTION_BITS_DEF = 4;
    // target = acc * 2^(8 - frac) / (9 * radius10), from 40960 / 1440 = 256 / 9
    localparam int TARGET_SCALE_LOG2 = 8;
    localparam int NEG_ROW_FIRST     = 3;
    localparam int SPEED_SCALE       = 1000;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [SPD_W-1:0] SPEED_MAX     = {SPD_W{1'b1}};
    localparam logic [DIV_W-1:0] TGT_POS_LIMIT = DIV_W'(32767);
    localparam logic [DIV_W-1:0] TGT_NEG_LIMIT = DIV_W'(32768);
    localparam logic signed [TGT_W-1:0] TGT_MAX = 16'sh7FFF;
    localparam logic signed [TGT_W-1:0] TGT_MIN = 16'sh8000;

    // coupling matrix scaled by 4
    localparam logic signed [COEF_W-1:0] COUPLING4 [SERVOS][JOINTS] = '{
        '{  6'sd20,  6'sd26,  6'sd30,  6'sd0  },
        '{ -6'sd10,  6'sd26,  6'sd30,  6'sd0  },
        '{  6'sd0,  -6'sd13,  6'sd30,  6'sd0  },
        '{  6'sd0,   6'sd0,  -6'sd15,  6'sd30 },
        '{  6'sd0,   6'sd0,  -6'sd15, -6'sd30 }
    };

    // floor(n / 9R) = (n * RECIP9R) >> RECIP_SHIFT, exact for every n below 2^DIV_W
    // since each 9R is below 2^10
    localparam int RECIP_SHIFT = DIV_W + 10;
    localparam int RECIP_W     = 29;

    // ceil(2^RECIP_SHIFT / (9 * radius scaled by 10)) for 990, 711, 396, 990, 990
    localparam logic [RECIP_W-1:0] RECIP9R [SERVOS] = '{
        29'd138827226, 29'd193303733, 29'd347068065, 29'd138827226, 29'd138827226
    };

    typedef logic signed [ANGLE_W-1:0] t_angle;

    typedef struct packed {
        t_angle              angle_alpha;
        t_angle              angle_beta;
        t_angle              angle_gamma;
        t_angle              angle_theta;
        logic [TIME_W-1:0]   move_time_ms;
        logic                zero_time;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_status;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

[hdl/jtsp_if.sv]
// Request channels of the mapper: joint request in, servo command out.
// Depends on jtsp_pkg for field widths.
interface jtsp_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [jtsp_pkg::ANGLE_W-1:0] angle_alpha;
    logic signed [jtsp_pkg::ANGLE_W-1:0] angle_beta;
    logic signed [jtsp_pkg::ANGLE_W-1:0] angle_gamma;
    logic signed [jtsp_pkg::ANGLE_W-1:0] angle_theta;
    logic [jtsp_pkg::TIME_W-1:0]         move_time_ms;

    modport source (output valid, angle_alpha, angle_beta, angle_gamma, angle_theta,
                    move_time_ms, input ready);
    modport sink   (input valid, angle_alpha, angle_beta, angle_gamma, angle_theta,
                    move_time_ms, output ready);
endinterface

interface jtsp_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [jtsp_pkg::TGT_W-1:0] target_one;
    logic signed [jtsp_pkg::TGT_W-1:0] target_two;
    logic signed [jtsp_pkg::TGT_W-1:0] target_three;
    logic signed [jtsp_pkg::TGT_W-1:0] target_four;
    logic signed [jtsp_pkg::TGT_W-1:0] target_five;
    logic [jtsp_pkg::SPD_W-1:0]        speed_one;
    logic [jtsp_pkg::SPD_W-1:0]        speed_two;
    logic [jtsp_pkg::SPD_W-1:0]        speed_three;
    logic [jtsp_pkg::SPD_W-1:0]        speed_four;
    logic [jtsp_pkg::SPD_W-1:0]        speed_five;

    modport source (output valid, target_one, target_two, target_three, target_four,
                    target_five, speed_one, speed_two, speed_three, speed_four,
                    speed_five, input ready);
    modport sink   (input valid, target_one, target_two, target_three, target_four,
                    target_five, speed_one, speed_two, speed_three, speed_four,
                    speed_five, output ready);
endinterface

[hdl/jtsp_front.sv]
// Front end: takes joint requests, flags a zero move time and pushes them to the queue.
// Depends on jtsp_pkg and jtsp_in_if.
module jtsp_front (
    jtsp_in_if.sink        i_in,
    input  logic           i_full,
    output logic           o_push,
    output jtsp_pkg::t_item o_item
);

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_item.angle_alpha  = i_in.angle_alpha;
        o_item.angle_beta   = i_in.angle_beta;
        o_item.angle_gamma  = i_in.angle_gamma;
        o_item.angle_theta  = i_in.angle_theta;
        o_item.move_time_ms = i_in.move_time_ms;
        // zero time saturates every speed, so the back end skips those divides
        o_item.zero_time    = (i_in.move_time_ms == '0);
    end

endmodule

[hdl/jtsp_fifo.sv]
// Short request queue between front and back end.
// Depends on jtsp_pkg for the item type.
module jtsp_fifo #(
    parameter int DEPTH = jtsp_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  jtsp_pkg::t_item     i_item,
    output logic                o_full,
    input  logic                i_pop,
    output jtsp_pkg::t_q_status o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jtsp_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;

    assign o_full       = (r_cnt == CNT_W'(DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10: begin
                n_cnt = r_cnt + 1'b1;
            end
            2'b01: begin
                n_cnt = r_cnt - 1'b1;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

[hdl/jtsp_div.sv]
// Shared serial restoring divider, one quotient bit per cycle.
// Depends on jtsp_pkg for request and response types.
module jtsp_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  jtsp_pkg::t_div_req i_req,
    output jtsp_pkg::t_div_rsp o_rsp
);

    localparam int DIV_W = jtsp_pkg::DIV_W;
    localparam int DEN_W = jtsp_pkg::DEN_W;
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DIV_W-1:0] r_quo;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = (trial >= {1'b0, r_den});

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so it fits DEN_W bits
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], fits};
        end
    end

endmodule

[hdl/jtsp_back.sv]
// Back end: per servo, coupling sum, reciprocal target scaling, speed divide, command register.
// Depends on jtsp_pkg, jtsp_out_if and jtsp_div.
module jtsp_back #(
    parameter int ANGLE_FRACTION_BITS = jtsp_pkg::ANGLE_FRACTION_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jtsp_pkg::t_q_status i_head,
    output logic                o_pop,
    jtsp_out_if.source          o_out
);

    localparam int SERVOS      = jtsp_pkg::SERVOS;
    localparam int JOINTS      = jtsp_pkg::JOINTS;
    localparam int IDX_W       = jtsp_pkg::IDX_W;
    localparam int ACC_W       = jtsp_pkg::ACC_W;
    localparam int DIV_W       = jtsp_pkg::DIV_W;
    localparam int TGT_W       = jtsp_pkg::TGT_W;
    localparam int SPD_W       = jtsp_pkg::SPD_W;
    localparam int SHIFT       = jtsp_pkg::TARGET_SCALE_LOG2 - ANGLE_FRACTION_BITS;
    localparam int RECIP_SHIFT = jtsp_pkg::RECIP_SHIFT;
    localparam int PROD_W      = DIV_W + jtsp_pkg::RECIP_W;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_TGT      = 7'b0000010,
        ST_MUL      = 7'b0000100,
        ST_SAT      = 7'b0001000,
        ST_SPD      = 7'b0010000,
        ST_SPD_WAIT = 7'b0100000,
        ST_DONE     = 7'b1000000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        n_idx;
    logic                    r_neg;
    logic                    n_neg;
    logic [DIV_W-1:0]        r_mag;
    logic [DIV_W-1:0]        n_mag;
    logic [DIV_W-1:0]        r_tq;
    logic [DIV_W-1:0]        n_tq;
    logic [TGT_W-1:0]        r_diff;
    logic [TGT_W-1:0]        n_diff;
    logic                    r_out_valid;
    logic                    n_out_valid;
    logic signed [TGT_W-1:0] r_prev [SERVOS];
    logic [SPD_W-1:0]        r_spd [SERVOS];
    logic signed [TGT_W-1:0] r_out_tgt [SERVOS];
    logic [SPD_W-1:0]        r_out_spd [SERVOS];

    jtsp_pkg::t_angle        ang [JOINTS];
    logic signed [ACC_W-1:0] acc;
    logic [ACC_W-1:0]        acc_abs;
    logic [DIV_W-1:0]        mag;
    logic                    row_flip;
    logic [PROD_W-1:0]       prod;
    logic [DIV_W-1:0]        quo;
    logic signed [TGT_W-1:0] t_new;
    logic signed [TGT_W:0]   dlt;
    logic [TGT_W:0]          dlt_abs;
    logic [SPD_W-1:0]        speed;
    logic                    load;
    logic                    prev_we;
    logic                    spd_we;
    logic                    advance;
    logic [SPD_W-1:0]        spd_val;

    jtsp_pkg::t_div_req      div_req;
    jtsp_pkg::t_div_rsp      div_rsp;

    jtsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign ang[0] = i_head.item.angle_alpha;
    assign ang[1] = i_head.item.angle_beta;
    assign ang[2] = i_head.item.angle_gamma;
    assign ang[3] = i_head.item.angle_theta;

    // coupling sum for the current row
    always_comb begin
        acc = '0;
        for (int j = 0; j < JOINTS; j++) begin
            acc = acc + ACC_W'(jtsp_pkg::COUPLING4[r_idx][j]) * ACC_W'(ang[j]);
        end
    end

    assign acc_abs  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    assign mag      = DIV_W'(acc_abs) << SHIFT;
    assign row_flip = (r_idx >= IDX_W'(jtsp_pkg::NEG_ROW_FIRST));
    assign quo      = div_rsp.quotient;

    // magnitude over 9R by reciprocal multiply
    assign prod = PROD_W'(r_mag) * PROD_W'(jtsp_pkg::RECIP9R[r_idx]);

    // sign back and saturate the truncated magnitude
    always_comb begin
        if (r_neg) begin
            t_new = (r_tq > jtsp_pkg::TGT_NEG_LIMIT) ? jtsp_pkg::TGT_MIN
                                                     : -$signed(r_tq[TGT_W-1:0]);
        end else begin
            t_new = (r_tq > jtsp_pkg::TGT_POS_LIMIT) ? jtsp_pkg::TGT_MAX
                                                     : $signed(r_tq[TGT_W-1:0]);
        end
    end

    assign dlt     = {t_new[TGT_W-1], t_new} - {r_prev[r_idx][TGT_W-1], r_prev[r_idx]};
    assign dlt_abs = dlt[TGT_W] ? (TGT_W + 1)'(-dlt) : (TGT_W + 1)'(dlt);
    assign speed   = (quo >= DIV_W'(jtsp_pkg::SPEED_MAX)) ? jtsp_pkg::SPEED_MAX
                                                          : quo[SPD_W-1:0] + 1'b1;

    always_comb begin
        div_req.start    = (r_state == ST_SPD);
        div_req.dividend = DIV_W'(r_diff) * DIV_W'(jtsp_pkg::SPEED_SCALE);
        div_req.divisor  = i_head.item.move_time_ms;
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_tq    = r_tq;
        n_diff  = r_diff;
        load    = 1'b0;
        o_pop   = 1'b0;
        prev_we = 1'b0;
        spd_we  = 1'b0;
        spd_val = '0;
        advance = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_head.valid) begin
                    n_state = ST_TGT;
                    n_idx   = '0;
                end
            end
            ST_TGT: begin
                n_mag   = mag;
                n_neg   = acc[ACC_W-1] ^ row_flip;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_tq    = DIV_W'(prod[PROD_W-1:RECIP_SHIFT]);
                n_state = ST_SAT;
            end
            ST_SAT: begin
                prev_we = 1'b1;
                n_diff  = dlt_abs[TGT_W-1:0];
                if (i_head.item.zero_time) begin
                    spd_we  = 1'b1;
                    spd_val = jtsp_pkg::SPEED_MAX;
                    advance = 1'b1;
                end else begin
                    n_state = ST_SPD;
                end
            end
            ST_SPD: begin
                n_state = ST_SPD_WAIT;
            end
            ST_SPD_WAIT: begin
                if (div_rsp.done) begin
                    spd_we  = 1'b1;
                    spd_val = speed;
                    advance = 1'b1;
                end
            end
            ST_DONE: begin
                // hand over once the command register is free
                if (!r_out_valid || o_out.ready) begin
                    load    = 1'b1;
                    o_pop   = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (advance) begin
            if (r_idx == IDX_W'(SERVOS - 1)) begin
                n_state = ST_DONE;
            end else begin
                n_idx   = r_idx + 1'b1;
                n_state = ST_TGT;
            end
        end
        n_out_valid = load ? 1'b1 : (r_out_valid && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SERVOS; i++) begin
                r_prev[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (prev_we) begin
                r_prev[r_idx] <= t_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_tq   <= n_tq;
        r_diff <= n_diff;
        if (spd_we) begin
            r_spd[r_idx] <= spd_val;
        end
        if (load) begin
            for (int i = 0; i < SERVOS; i++) begin
                r_out_tgt[i] <= r_prev[i];
                r_out_spd[i] <= r_spd[i];
            end
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.target_one   = r_out_tgt[0];
    assign o_out.target_two   = r_out_tgt[1];
    assign o_out.target_three = r_out_tgt[2];
    assign o_out.target_four  = r_out_tgt[3];
    assign o_out.target_five  = r_out_tgt[4];
    assign o_out.speed_one    = r_out_spd[0];
    assign o_out.speed_two    = r_out_spd[1];
    assign o_out.speed_three  = r_out_spd[2];
    assign o_out.speed_four   = r_out_spd[3];
    assign o_out.speed_five   = r_out_spd[4];

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head.valid)
        else $error("queue popped while empty");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_out_valid || o_out.ready))
        else $error("command register overwritten before it was taken");

    a_no_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !div_rsp.done)
        else $error("divider finished with no servo pending");

    a_start_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDX_W'(SERVOS - 1))
        else $error("servo index out of range");

endmodule

[hdl/joint_to_servo_position_speed.sv]
// Joint-to-servo mapper: four joint angles and a move time in, five targets and speeds out.
// Each request is worked servo by servo: coupling sum, reciprocal multiply, saturation and
// speed divide, with the divide skipped at zero move time; the command register then loads
// once the previous command is taken. One request is worked at a time on the single serial
// divider (five 27-step divides per request); a two-entry queue holds it and one more.
// Synchronous active-low reset clears the queue, the sequencer and the previous targets.
module joint_to_servo_position_speed #(
    parameter int ANGLE_FRACTION_BITS = jtsp_pkg::ANGLE_FRACTION_BITS_DEF,
    parameter int QUEUE_DEPTH         = jtsp_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jtsp_in_if.sink    i_in,
    jtsp_out_if.source o_out
);

    logic                full;
    logic                push;
    logic                pop;
    jtsp_pkg::t_item     item;
    jtsp_pkg::t_q_status head;

    jtsp_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_item (item)
    );

    jtsp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head)
    );

    jtsp_back #(
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
